/* src/tsa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tsa_pkg;

    localparam int ANGLE_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int TPD_W      = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FULL_W     = 7;
    localparam int SPEED_W    = 8;
    localparam int DIVISOR_W  = 6;

    localparam logic [FULL_W-1:0] FULL_SPEED_MAX = 7'd100;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_SPAN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ANGLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SPEED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TPD_RIGHT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TPD_LEFT      = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SAT,
        S_MAG,
        S_BKT,
        S_DSTART,
        S_DIV,
        S_DEG,
        S_MULLO,
        S_MULHI,
        S_TURN,
        S_DLINE,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load_in;
        logic sat;
        logic mag;
        logic bkt;
        logic div_start;
        logic deg;
        logic mul_lo;
        logic mul_hi;
        logic turn;
        logic dline;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic op_stop;
        logic changed;
        logic limit_run;
        logic div_done;
    } t_dp_status;

    // drive magnitude of each distance bucket
    function automatic logic [SPEED_W-1:0] bucket_speed(input logic [1:0] bkt);
        logic [SPEED_W-1:0] s;
        unique case (bkt)
            2'd0: s = 8'd40;
            2'd1: s = 8'd38;
            2'd2: s = 8'd35;
            2'd3: s = 8'd30;
        endcase
        return s;
    endfunction

    // reduced overshoot divisor: span*2^15/19, 9*span*2^14/35, span*2^15/3
    function automatic logic [DIVISOR_W-1:0] ovs_divisor(input logic [1:0] bkt);
        logic [DIVISOR_W-1:0] d;
        unique case (bkt)
            2'd0: d = 6'd3;
            2'd1: d = 6'd19;
            2'd2: d = 6'd35;
            2'd3: d = 6'd3;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* src/tsa_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsa_div
    import tsa_pkg::*;
#(
    parameter int DW = ANGLE_BITS_DEF + 18
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DW-1:0]        i_dividend,
    input  wire logic [DIVISOR_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [DW-1:0]             o_quotient
);

    localparam int BPC   = 8;
    localparam int STEPS = (DW + BPC - 1) / BPC;
    localparam int PADW  = STEPS * BPC;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                 r_busy;
    logic [CW-1:0]        r_cnt;
    logic [PADW-1:0]      r_num, n_num;
    logic [PADW-1:0]      r_quo, n_quo;
    logic [DIVISOR_W-1:0] r_rem, n_rem;
    logic [DIVISOR_W-1:0] r_div;
    logic [DIVISOR_W:0]   t_try;

    // eight restoring steps per cycle, remainder stays below the divisor
    always_comb begin
        n_num = r_num;
        n_quo = r_quo;
        n_rem = r_rem;
        t_try = '0;
        for (int k = 0; k < BPC; k++) begin
            t_try = {n_rem, n_num[PADW-1]};
            n_num = {n_num[PADW-2:0], 1'b0};
            if (t_try >= {1'b0, r_div}) begin
                n_rem = DIVISOR_W'(t_try - {1'b0, r_div});
                n_quo = {n_quo[PADW-2:0], 1'b1};
            end else begin
                n_rem = t_try[DIVISOR_W-1:0];
                n_quo = {n_quo[PADW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(STEPS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= PADW'(i_dividend);
            r_quo <= '0;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= n_num;
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_quo[DW-1:0];

endmodule

`default_nettype wire

/* src/tsa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsa_ctrl
    import tsa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SAT;
                end
            end
            S_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = i_status.op_stop ? S_FIN : S_MAG;
            end
            S_MAG: begin
                o_cmd.mag = 1'b1;
                n_state   = S_BKT;
            end
            S_BKT: begin
                o_cmd.bkt = 1'b1;
                if (!i_status.changed || i_status.limit_run) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_DSTART;
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_DEG;
                end
            end
            S_DEG: begin
                o_cmd.deg = 1'b1;
                n_state   = S_MULLO;
            end
            S_MULLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MULHI;
            end
            S_MULHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_TURN;
            end
            S_TURN: begin
                o_cmd.turn = 1'b1;
                n_state    = S_DLINE;
            end
            S_DLINE: begin
                o_cmd.dline = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* src/tsa_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsa_dp
    import tsa_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_dp_cmd                      i_cmd,
    output t_dp_status                        o_status,
    input  wire logic                         i_opcode,
    input  wire logic signed [ANGLE_BITS-1:0] i_wanted_angle,
    input  wire logic [TIME_BITS-1:0]         i_now_us,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic                              o_drive_enable,
    output logic signed [SPEED_W-1:0]         o_drive_speed,
    output logic signed [ANGLE_BITS-1:0]      o_angle_estimate
);

    localparam int AB    = ANGLE_BITS;
    localparam int DIVW  = AB + 18;
    localparam int DW    = AB + 17;
    localparam int MULW  = DW + FRAC_BITS;
    localparam int TURNW = MULW + 1 - FRAC_BITS;
    localparam int SUMW  = (TIME_BITS > TURNW) ? TIME_BITS : TURNW;

    // configuration
    logic signed [AB-1:0] r_left, r_right;
    logic [AB-1:0]        r_span;
    logic [FULL_W-1:0]    r_full;
    logic [TPD_W-1:0]     r_tpd_r, r_tpd_l;

    // block state
    logic signed [AB-1:0]       r_believed, r_last;
    logic [TIME_BITS-1:0]       r_stop_dl;
    logic                       r_latched, r_on;
    logic signed [SPEED_W-1:0]  r_value;

    // per transaction working registers
    logic                 r_op;
    logic signed [AB-1:0] r_wanted, r_cmd;
    logic [TIME_BITS-1:0] r_now, r_dl_new;
    logic [AB-1:0]        r_mag;
    logic                 r_neg, r_pos, r_changed, r_limit_run;
    logic [1:0]           r_bkt;
    logic [DW-1:0]        r_deg;
    logic [MULW-1:0]      r_plo, r_phi;
    logic [TURNW-1:0]     r_turn;

    logic signed [AB-1:0] cap, sat;
    logic signed [AB:0]   diff;
    logic [AB:0]          diff_abs;
    logic [AB+1:0]        mag4, sp1, sp2, sp3, sp4;
    logic [1:0]           bkt;
    logic [AB+3:0]        span9;
    logic [DIVW-1:0]      dividend;
    logic                 div_done;
    logic [DIVW-1:0]      quotient;
    logic [DW-1:0]        ovs, deg;
    logic [TPD_W-1:0]     tpd;
    logic [MULW:0]        turn_sum;
    logic [SUMW-1:0]      dl_sum;

    logic [TIME_BITS-1:0]      dl_eff;
    logic                      latched_eff, on_eff, stop_now;
    logic signed [SPEED_W-1:0] value_eff, bspeed;
    logic [FULL_W-1:0]         full_sat;
    logic signed [AB-1:0]      believed_eff;

    tsa_div #(.DW(DIVW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (ovs_divisor(r_bkt)),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        o_status.op_stop   = r_op;
        o_status.changed   = r_changed;
        o_status.limit_run = r_limit_run;
        o_status.div_done  = div_done;
    end

    // saturation, right limit wins on conflict
    assign cap = (r_wanted > r_left) ? r_left : r_wanted;
    assign sat = (cap < r_right) ? r_right : cap;

    assign diff     = {r_cmd[AB-1], r_cmd} - {r_believed[AB-1], r_believed};
    assign diff_abs = diff[AB] ? (AB+1)'(-diff) : diff;

    // bucket bounds at quarters of the span
    assign mag4 = {r_mag, 2'b00};
    assign sp1  = {2'b00, r_span};
    assign sp2  = {1'b0, r_span, 1'b0};
    assign sp3  = sp1 + sp2;
    assign sp4  = {r_span, 2'b00};

    always_comb begin
        priority if (mag4 <= sp1) begin
            bkt = 2'd0;
        end else if (mag4 <= sp2) begin
            bkt = 2'd1;
        end else if (mag4 <= sp3) begin
            bkt = 2'd2;
        end else begin
            bkt = 2'd3;
        end
    end

    assign span9    = (AB+4)'(r_span) * (AB+4)'(9);
    assign dividend = (r_bkt == 2'd2) ? (DIVW'(span9) << 14) : (DIVW'(r_span) << 15);

    assign ovs = (r_bkt == 2'd0) ? '0 : quotient[DW-1:0];
    assign deg = DW'({r_mag, {FRAC_BITS{1'b0}}}) + ovs;

    assign tpd      = r_pos ? r_tpd_r : r_tpd_l;
    assign turn_sum = (MULW+1)'(r_phi) + (MULW+1)'(r_plo >> FRAC_BITS);
    assign dl_sum   = SUMW'(r_now) + SUMW'(r_turn);

    // state update of the final step
    assign full_sat = (r_full > FULL_SPEED_MAX) ? FULL_SPEED_MAX : r_full;
    assign bspeed   = r_neg ? -$signed(bucket_speed(r_bkt)) : $signed(bucket_speed(r_bkt));

    always_comb begin
        dl_eff      = r_stop_dl;
        latched_eff = r_latched;
        on_eff      = r_on;
        value_eff   = r_value;
        if (r_op) begin
            latched_eff = 1'b1;
            on_eff      = 1'b0;
        end else if (r_changed) begin
            on_eff = 1'b1;
            if (r_limit_run) begin
                value_eff = $signed({1'b0, full_sat});
                dl_eff    = '1;
            end else begin
                value_eff   = bspeed;
                dl_eff      = r_dl_new;
                latched_eff = 1'b0;
            end
        end
        stop_now     = !r_op && ((r_now > dl_eff) || latched_eff);
        believed_eff = stop_now ? r_cmd : r_believed;
        if (stop_now) begin
            on_eff = 1'b0;
        end
    end

    // configuration and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_right    <= '0;
            r_span     <= AB'(1);
            r_full     <= '0;
            r_tpd_r    <= '0;
            r_tpd_l    <= '0;
            r_believed <= '0;
            r_last     <= '0;
            r_stop_dl  <= '0;
            r_latched  <= 1'b0;
            r_on       <= 1'b0;
            r_value    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LEFT_LIMIT:  r_left  <= i_cfg_data[AB-1:0];
                CFG_RIGHT_LIMIT: r_right <= i_cfg_data[AB-1:0];
                CFG_ANGLE_SPAN:  r_span  <= i_cfg_data[AB-1:0];
                CFG_INITIAL_ANGLE: begin
                    r_believed <= i_cfg_data[AB-1:0];
                    r_last     <= i_cfg_data[AB-1:0];
                end
                CFG_FULL_SPEED:  r_full  <= i_cfg_data[FULL_W-1:0];
                CFG_TPD_RIGHT:   r_tpd_r <= i_cfg_data[TPD_W-1:0];
                CFG_TPD_LEFT:    r_tpd_l <= i_cfg_data[TPD_W-1:0];
                default: ;
            endcase
        end else if (i_cmd.finish) begin
            r_believed <= believed_eff;
            r_stop_dl  <= dl_eff;
            r_latched  <= latched_eff;
            r_on       <= on_eff;
            r_value    <= value_eff;
            if (!r_op && r_changed) begin
                r_last <= r_cmd;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op     <= i_opcode;
            r_wanted <= i_wanted_angle;
            r_now    <= i_now_us;
        end
        if (i_cmd.sat) begin
            r_cmd <= sat;
        end
        if (i_cmd.mag) begin
            r_mag       <= diff_abs[AB-1:0];
            r_neg       <= diff[AB];
            r_pos       <= !diff[AB] && (diff != '0);
            r_changed   <= (r_cmd != r_last);
            r_limit_run <= ((r_cmd == r_left) || (r_cmd == r_right)) && !r_latched;
        end
        if (i_cmd.bkt) begin
            r_bkt <= bkt;
        end
        if (i_cmd.deg) begin
            r_deg <= deg;
        end
        if (i_cmd.mul_lo) begin
            r_plo <= MULW'(r_deg) * MULW'(tpd[FRAC_BITS-1:0]);
        end
        if (i_cmd.mul_hi) begin
            r_phi <= MULW'(r_deg) * MULW'(tpd[TPD_W-1:FRAC_BITS]);
        end
        if (i_cmd.turn) begin
            r_turn <= turn_sum[MULW:FRAC_BITS];
        end
        if (i_cmd.dline) begin
            r_dl_new <= dl_sum[TIME_BITS-1:0];
        end
        if (i_cmd.finish) begin
            o_drive_enable   <= on_eff;
            o_drive_speed    <= on_eff ? value_eff : '0;
            o_angle_estimate <= believed_eff;
        end
    end

endmodule

`default_nettype wire

/* src/timed_steering_actuator_control.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake                 payload
// input    in         i_in_valid / o_in_ready   i_opcode, i_wanted_angle, i_now_us
// result   out        o_out_valid / i_out_ready o_drive_enable, o_drive_speed,
//                                               o_angle_estimate
// config   in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// one transaction at a time; an end-stop event goes from saturation straight to
// the result, a repeated or end-stop command also passes the distance and bucket
// steps, and a timed turn further runs the 8-bit-per-cycle overshoot divider, the
// two 16-bit halves of the time multiply, the turn sum and the deadline
// the next transaction can be taken in the cycle after the result is registered
// synchronous active-low reset clears control, configuration and block state
// a stalled result holds in the output register; only the final step waits on it

module timed_steering_actuator_control
    import tsa_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_opcode,
    input  wire logic signed [ANGLE_BITS-1:0] i_wanted_angle,
    input  wire logic [TIME_BITS-1:0]         i_now_us,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_drive_enable,
    output logic signed [SPEED_W-1:0]         o_drive_speed,
    output logic signed [ANGLE_BITS-1:0]      o_angle_estimate,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data
);

    // controller to datapath commands and back
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer: walks saturate, distance, bucket, divide, multiply, deadline
    tsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // datapath: configuration, steering state, arithmetic and result register
    tsa_dp #(
        .ANGLE_BITS (ANGLE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_opcode         (i_opcode),
        .i_wanted_angle   (i_wanted_angle),
        .i_now_us         (i_now_us),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_drive_enable   (o_drive_enable),
        .o_drive_speed    (o_drive_speed),
        .o_angle_estimate (o_angle_estimate)
    );

`ifndef SYNTH
    // a new transaction is never taken in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // a disabled motor always reports zero speed
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_drive_enable) |-> (o_drive_speed == '0))
        else $error("nonzero speed with drive disabled");

    // speed command stays within the drive range
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_drive_speed <= 8'sd100) && (o_drive_speed >= -8'sd100)))
        else $error("speed command out of range");
`endif

endmodule

`default_nettype wire
